// ===== sv/label_map_adjacency_pairs_top_defines.svh =====
// Assertion macros shared by the label map adjacency block
`ifndef LABEL_MAP_ADJACENCY_PAIRS_TOP_DEFINES_SVH
`define LABEL_MAP_ADJACENCY_PAIRS_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define LMAP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define LMAP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lmap_adj_pkg.sv =====
package lmap_adj_pkg;

    // Default sizes
    localparam int DEF_MAX_LABELS = 256;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WIDTH  = 4096;

    // Field widths
    localparam int HEIGHT_W  = 11;
    localparam int WIDTH_W   = 13;
    localparam int COUNT_W   = 9;
    localparam int RAW_W     = 16;
    localparam int OUT_LBL_W = 8;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Register indexes
    typedef enum logic [1:0] {
        REG_HEIGHT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_COUNT  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

endpackage

// ===== sv/lmap_adj_ram.sv =====
module lmap_adj_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/label_map_adjacency_pairs_top.sv =====
// Pixel transaction: S_COLA and S_COLB, then S_PRD and S_PWR for each pair marked (up to four).
// Fetch transaction: S_SCAN reads one pair-store word at a time through the
//   single read port of the pair store, then S_OUT; the result sits in an output register.
// Clear transaction and reset: a sweep writes zero to every pair-store word, one a
//   cycle (1024 words at default sizes); s_tready stays low meanwhile.
// Reset is synchronous, active low; configuration registers return to their defaults.
`include "label_map_adjacency_pairs_top_defines.svh"

module label_map_adjacency_pairs_top
    import lmap_adj_pkg::*;
#(
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] label
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] source_label, [15:8] target_label, [16] range_error
    output logic        m_tuser    // [0] pair_found
);

    localparam int LW     = $clog2(MAX_LABELS);
    localparam int PW     = 2 * LW;
    localparam int PIW    = (PW > 7) ? PW : 7;
    localparam int AW     = PIW - 6;
    localparam int PDEPTH = 2 ** AW;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HCW    = (RW + 1 > HEIGHT_W) ? RW + 1 : HEIGHT_W;
    localparam int WCW    = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CLR  = 8'b0000_0010,
        S_COLA = 8'b0000_0100,
        S_COLB = 8'b0000_1000,
        S_PRD  = 8'b0001_0000,
        S_PWR  = 8'b0010_0000,
        S_SCAN = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // Lowest set bit of a word, byte first then bit
    function automatic logic [5:0] first_set(input logic [63:0] w);
        logic [7:0] nz;
        logic [2:0] bsel;
        logic [7:0] b;
        logic [2:0] ksel;
        nz   = '0;
        bsel = '0;
        ksel = '0;
        for (int j = 0; j < 8; j++) begin
            nz[j] = |w[8*j +: 8];
        end
        for (int j = 7; j >= 0; j--) begin
            if (nz[j]) bsel = 3'(j);
        end
        b = w[8*bsel +: 8];
        for (int k = 7; k >= 0; k--) begin
            if (b[k]) ksel = 3'(k);
        end
        return {bsel, ksel};
    endfunction

    state_t state_reg, state_next;

    logic [HEIGHT_W-1:0]  height_reg, height_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic           col_valid_reg, col_valid_next;
    logic [LW-1:0]  above_reg, above_next;
    logic           above_ok_reg, above_ok_next;
    logic [LW-1:0]  lup_reg, lup_next;
    logic           lup_ok_reg, lup_ok_next;
    logic           err_reg, err_next;
    logic [PIW:0]   scan_reg, scan_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [3:0]     slot_mask_reg, slot_mask_next;
    logic           m_valid_reg, m_valid_next;

    logic [RW-1:0]  pix_r_reg, pix_r_next;
    logic [LW-1:0]  pix_cur_reg, pix_cur_next;
    logic           pix_ok_reg, pix_ok_next;
    logic [LW-1:0]  slot_lbl_reg [4];
    logic [LW-1:0]  slot_lbl_next [4];
    logic [PIW-1:0] pair_idx_reg, pair_idx_next;
    logic [OUT_LBL_W-1:0] res_src_reg, res_src_next, res_tgt_reg, res_tgt_next;
    logic           res_found_reg, res_found_next, res_err_reg, res_err_next;
    logic [OUT_LBL_W-1:0] out_src_reg, out_src_next, out_tgt_reg, out_tgt_next;
    logic           out_found_reg, out_found_next, out_err_reg, out_err_next;

    logic           col_we;
    logic [RW-1:0]  col_waddr, col_raddr;
    logic [LW:0]    col_wdata, col_rdata;
    logic           pair_we;
    logic [AW-1:0]  pair_waddr, pair_raddr;
    logic [63:0]    pair_wdata, pair_rdata;

    logic           in_fire, cfg_we;
    logic [RAW_W-1:0] raw, n_eff;
    logic           px_ok;
    logic [HCW-1:0] h_raw, h_eff, r_plus;
    logic [WCW-1:0] w_raw, w_eff, c_plus;
    logic           nxt_ok;
    logic [3:0]     mask_tmp;
    logic [1:0]     sel;
    logic [LW-1:0]  s_lbl, t_lbl;
    logic [63:0]    masked;
    logic [5:0]     pos;
    logic [PIW:0]   scan_adv;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign raw      = s_tdata;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_tgt_reg, out_src_reg};
    assign m_tuser  = out_found_reg;

    // Effective sizes after clamping
    assign n_eff = (RAW_W'(count_reg) > RAW_W'(MAX_LABELS)) ? RAW_W'(MAX_LABELS)
                                                           : RAW_W'(count_reg);
    assign px_ok = (raw != '0) && (raw <= n_eff);
    assign h_raw = HCW'(height_reg);
    assign h_eff = (h_raw == '0) ? HCW'(1)
                 : ((h_raw > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_raw);
    assign w_raw = WCW'(width_reg);
    assign w_eff = (w_raw == '0) ? WCW'(1)
                 : ((w_raw > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_raw);
    assign r_plus = HCW'(pix_r_reg) + HCW'(1);
    assign c_plus = WCW'(col_reg) + WCW'(1);
    assign nxt_ok = (r_plus < h_eff);

    // Register read-back
    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_COUNT:  prdata = 32'(count_reg);
            default:    prdata = '0;
        endcase
    end

    lmap_adj_ram #(.WIDTH(LW + 1), .DEPTH(MAX_HEIGHT), .ADDR_W(RW)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    lmap_adj_ram #(.WIDTH(64), .DEPTH(PDEPTH), .ADDR_W(AW)) u_pair_ram (
        .aclk  (aclk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    // Sequencer: column lookups, pair read-modify-write, scan and clear sweep
    always_comb begin
        state_next     = state_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        count_next     = count_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        col_valid_next = col_valid_reg;
        above_next     = above_reg;
        above_ok_next  = above_ok_reg;
        lup_next       = lup_reg;
        lup_ok_next    = lup_ok_reg;
        err_next       = err_reg;
        scan_next      = scan_reg;
        clr_cnt_next   = clr_cnt_reg;
        slot_mask_next = slot_mask_reg;
        m_valid_next   = m_valid_reg;
        pix_r_next     = pix_r_reg;
        pix_cur_next   = pix_cur_reg;
        pix_ok_next    = pix_ok_reg;
        slot_lbl_next  = slot_lbl_reg;
        pair_idx_next  = pair_idx_reg;
        res_src_next   = res_src_reg;
        res_tgt_next   = res_tgt_reg;
        res_found_next = res_found_reg;
        res_err_next   = res_err_reg;
        out_src_next   = out_src_reg;
        out_tgt_next   = out_tgt_reg;
        out_found_next = out_found_reg;
        out_err_next   = out_err_reg;

        col_we     = 1'b0;
        col_waddr  = pix_r_reg;
        col_wdata  = {pix_ok_reg, pix_cur_reg};
        col_raddr  = row_reg;
        pair_we    = 1'b0;
        pair_waddr = pair_idx_reg[PIW-1:6];
        pair_wdata = pair_rdata | (64'd1 << pair_idx_reg[5:0]);
        pair_raddr = scan_reg[PIW-1:6];
        mask_tmp   = slot_mask_reg;
        sel        = '0;
        s_lbl      = '0;
        t_lbl      = '0;
        masked     = pair_rdata & ({64{1'b1}} << scan_reg[5:0]);
        pos        = first_set(masked);
        scan_adv   = {scan_reg[PIW:6] + (AW + 1)'(1), 6'd0};

        // Configuration writes
        if (cfg_we) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_HEIGHT: height_next = pwdata[HEIGHT_W-1:0];
                REG_WIDTH:  width_next  = pwdata[WIDTH_W-1:0];
                REG_COUNT:  count_next  = pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end

        // Drop the result once taken
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (req_t'(s_tuser))
                        REQ_PIXEL: begin
                            pix_r_next   = row_reg;
                            pix_ok_next  = px_ok;
                            pix_cur_next = LW'(raw - RAW_W'(1));
                            if (!px_ok) err_next = 1'b1;
                            state_next = S_COLA;
                        end
                        REQ_FETCH: begin
                            res_err_next = err_reg;
                            if (scan_reg[PIW]) begin
                                res_found_next = 1'b0;
                                res_src_next   = '0;
                                res_tgt_next   = '0;
                                state_next     = S_OUT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            row_next       = '0;
                            col_next       = '0;
                            col_valid_next = 1'b0;
                            above_ok_next  = 1'b0;
                            lup_ok_next    = 1'b0;
                            err_next       = 1'b0;
                            scan_next      = '0;
                            clr_cnt_next   = '0;
                            state_next     = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end

            S_CLR: begin
                pair_we      = 1'b1;
                pair_waddr   = clr_cnt_reg;
                pair_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == {AW{1'b1}}) state_next = S_IDLE;
            end

            S_COLA: begin
                // Same row of previous column is here; fetch the row below
                col_raddr        = RW'(r_plus);
                col_we           = 1'b1;
                slot_mask_next[0] = (pix_r_reg != '0) && above_ok_reg;
                slot_lbl_next[0]  = above_reg;
                slot_mask_next[1] = col_valid_reg && col_rdata[LW];
                slot_lbl_next[1]  = col_rdata[LW-1:0];
                slot_mask_next[2] = (pix_r_reg != '0) && lup_ok_reg && col_valid_reg;
                slot_lbl_next[2]  = lup_reg;
                slot_mask_next[3] = 1'b0;
                lup_next    = col_rdata[LW-1:0];
                lup_ok_next = col_valid_reg && col_rdata[LW];
                state_next  = S_COLB;
            end

            S_COLB: begin
                mask_tmp[3]      = col_valid_reg && nxt_ok && col_rdata[LW];
                slot_lbl_next[3] = col_rdata[LW-1:0];
                for (int i = 0; i < 3; i++) begin
                    mask_tmp[i] = slot_mask_reg[i] && (slot_lbl_reg[i] != pix_cur_reg);
                end
                mask_tmp[3] = mask_tmp[3] && (col_rdata[LW-1:0] != pix_cur_reg);
                mask_tmp    = mask_tmp & {4{pix_ok_reg}};
                slot_mask_next = mask_tmp;
                above_next     = pix_cur_reg;
                above_ok_next  = pix_ok_reg;
                // Advance frame position
                if (r_plus >= h_eff) begin
                    row_next = '0;
                    if (c_plus >= w_eff) begin
                        col_next       = '0;
                        col_valid_next = 1'b0;
                    end else begin
                        col_next       = CW'(c_plus);
                        col_valid_next = 1'b1;
                    end
                end else begin
                    row_next = RW'(r_plus);
                end
                state_next = (mask_tmp != '0) ? S_PRD : S_IDLE;
            end

            S_PRD: begin
                for (int i = 3; i >= 0; i--) begin
                    if (slot_mask_reg[i]) sel = 2'(i);
                end
                if (slot_lbl_reg[sel] < pix_cur_reg) begin
                    s_lbl = slot_lbl_reg[sel];
                    t_lbl = pix_cur_reg;
                end else begin
                    s_lbl = pix_cur_reg;
                    t_lbl = slot_lbl_reg[sel];
                end
                pair_idx_next       = PIW'({t_lbl, s_lbl});
                pair_raddr          = pair_idx_next[PIW-1:6];
                slot_mask_next[sel] = 1'b0;
                state_next          = S_PWR;
            end

            S_PWR: begin
                pair_we    = 1'b1;
                state_next = (slot_mask_reg != '0) ? S_PRD : S_IDLE;
            end

            S_SCAN: begin
                pair_raddr = AW'(scan_reg[PIW-1:6] + AW'(1));
                if (masked != '0) begin
                    pair_idx_next  = {scan_reg[PIW-1:6], pos};
                    scan_next      = (PIW + 1)'(pair_idx_next) + (PIW + 1)'(1);
                    res_found_next = 1'b1;
                    res_src_next   = OUT_LBL_W'(pair_idx_next[LW-1:0]);
                    res_tgt_next   = OUT_LBL_W'(pair_idx_next[PW-1:LW]);
                    state_next     = S_OUT;
                end else begin
                    scan_next = scan_adv;
                    if (scan_adv[PIW]) begin
                        res_found_next = 1'b0;
                        res_src_next   = '0;
                        res_tgt_next   = '0;
                        state_next     = S_OUT;
                    end
                end
            end

            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_src_next   = res_src_reg;
                    out_tgt_next   = res_tgt_reg;
                    out_found_next = res_found_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            height_reg    <= HEIGHT_W'(1);
            width_reg     <= WIDTH_W'(1);
            count_reg     <= COUNT_W'(256);
            row_reg       <= '0;
            col_reg       <= '0;
            col_valid_reg <= 1'b0;
            above_reg     <= '0;
            above_ok_reg  <= 1'b0;
            lup_reg       <= '0;
            lup_ok_reg    <= 1'b0;
            err_reg       <= 1'b0;
            scan_reg      <= '0;
            clr_cnt_reg   <= '0;
            slot_mask_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            height_reg    <= height_next;
            width_reg     <= width_next;
            count_reg     <= count_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            col_valid_reg <= col_valid_next;
            above_reg     <= above_next;
            above_ok_reg  <= above_ok_next;
            lup_reg       <= lup_next;
            lup_ok_reg    <= lup_ok_next;
            err_reg       <= err_next;
            scan_reg      <= scan_next;
            clr_cnt_reg   <= clr_cnt_next;
            slot_mask_reg <= slot_mask_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        pix_r_reg     <= pix_r_next;
        pix_cur_reg   <= pix_cur_next;
        pix_ok_reg    <= pix_ok_next;
        slot_lbl_reg  <= slot_lbl_next;
        pair_idx_reg  <= pair_idx_next;
        res_src_reg   <= res_src_next;
        res_tgt_reg   <= res_tgt_next;
        res_found_reg <= res_found_next;
        res_err_reg   <= res_err_next;
        out_src_reg   <= out_src_next;
        out_tgt_reg   <= out_tgt_next;
        out_found_reg <= out_found_next;
        out_err_reg   <= out_err_next;
    end

    `LMAP_ASSERT(a_pair_write_state, pair_we |-> (state_reg == S_PWR || state_reg == S_CLR), "pair store written outside an update or clear")
    `LMAP_ASSERT(a_no_pair_zero, (m_tvalid && !m_tuser) |-> (m_tdata[15:0] == 16'd0), "empty fetch result carries labels")
    `LMAP_ASSERT_NEXT(a_clear_sweep, in_fire && (s_tuser == REQ_CLEAR), state_reg == S_CLR && !s_tready, "clear transaction did not start a sweep")

endmodule

// ===== tb/tb_label_map_adjacency_pairs_top.sv =====
`timescale 1ns / 1ps

module tb_label_map_adjacency_pairs_top;
    import lmap_adj_pkg::*;

    localparam int NLBL = 256;
    localparam int NHGT = 1024;
    localparam int NWID = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 4000;

    typedef struct packed {
        req_t        kind;
        logic [15:0] label;
    } request_t;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] tgt;
        logic       found;
        logic       err;
    } pair_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    label_map_adjacency_pairs_top u_top (.*);

    always #6 aclk = ~aclk;

    // Predictor state
    int unsigned cfg_height = 1, cfg_width = 1, cfg_count = 256;
    int unsigned prev_col[NHGT];
    bit          prev_ok[NHGT];
    bit          have_prev_col;
    int unsigned row_pos, col_pos;
    int unsigned above_lbl, diag_lbl;
    bit          above_ok, diag_ok;
    bit          adjacency[NLBL*NLBL];
    int unsigned scan_pos;
    bit          sticky_err;

    request_t    pending_requests[$];
    pair_reply_t expected_pairs[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          fetch_count = 0, found_count = 0;
    bit          long_hold = 1'b0;
    int          hold_cycles = 0;
    int          tx_gap = 0, rx_gap = 0;
    int          accept_count = 0, accept_seen = 0;
    int          recv_count = 0, recv_seen = 0;

    function automatic void restart_scan();
        for (int i = 0; i < NHGT; i++) begin
            prev_col[i] = 0;
            prev_ok[i] = 1'b0;
        end
        for (int i = 0; i < NLBL*NLBL; i++) adjacency[i] = 1'b0;
        have_prev_col = 1'b0;
        row_pos = 0;
        col_pos = 0;
        above_lbl = 0;
        above_ok = 1'b0;
        diag_lbl = 0;
        diag_ok = 1'b0;
        scan_pos = 0;
        sticky_err = 1'b0;
    endfunction

    function automatic void link_labels(int unsigned a, int unsigned b);
        int unsigned lo, hi;
        if (a == b || a >= NLBL || b >= NLBL) return;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        adjacency[hi*NLBL + lo] = 1'b1;
    endfunction

    function automatic void absorb_pixel(int unsigned raw);
        int unsigned h, w, n, r, cur;
        bit ok;
        h = (cfg_height < 1) ? 1 : (cfg_height > NHGT ? NHGT : cfg_height);
        w = (cfg_width < 1) ? 1 : (cfg_width > NWID ? NWID : cfg_width);
        n = (cfg_count > NLBL) ? NLBL : cfg_count;
        r = (row_pos >= NHGT) ? 0 : row_pos;
        ok = raw >= 1 && raw <= n;
        cur = ok ? raw - 1 : 0;
        if (!ok) sticky_err = 1'b1;
        if (ok) begin
            if (r > 0 && above_ok) link_labels(cur, above_lbl);
            if (have_prev_col) begin
                if (prev_ok[r]) link_labels(cur, prev_col[r]);
                if (r > 0 && diag_ok) link_labels(cur, diag_lbl);
                if (r + 1 < h && r + 1 < NHGT && prev_ok[r+1])
                    link_labels(cur, prev_col[r+1]);
            end
        end
        diag_lbl = prev_col[r];
        diag_ok = have_prev_col && prev_ok[r];
        prev_col[r] = cur;
        prev_ok[r] = ok;
        above_lbl = cur;
        above_ok = ok;
        if (r + 1 >= h) begin
            row_pos = 0;
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                have_prev_col = 1'b0;
            end else begin
                col_pos++;
                have_prev_col = 1'b1;
            end
        end else begin
            row_pos = r + 1;
        end
    endfunction

    function automatic pair_reply_t next_pair();
        pair_reply_t rep;
        rep = '0;
        rep.err = sticky_err;
        while (scan_pos < NLBL*NLBL) begin
            if (adjacency[scan_pos]) begin
                rep.src = 8'(scan_pos % NLBL);
                rep.tgt = 8'(scan_pos / NLBL);
                rep.found = 1'b1;
                scan_pos++;
                return rep;
            end
            scan_pos++;
        end
        return rep;
    endfunction

    // Driver: present one queued request at a time after its random gap
    always @(negedge aclk) begin
        if (aresetn) begin
            if (accept_count != accept_seen) begin
                // drop the taken transaction and draw the next gap
                accept_seen <= accept_count;
                s_tvalid <= 1'b0;
                tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else if (s_tvalid) begin
                // hold the current transaction
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
            end else if (pending_requests.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_requests[0].kind;
                s_tdata <= pending_requests[0].label;
            end
        end
    end

    // Accept: predict on each input transaction
    always @(posedge aclk) begin
        request_t rq;
        if (aresetn && s_tvalid && s_tready) begin
            rq = pending_requests.pop_front();
            case (rq.kind)
                REQ_PIXEL: absorb_pixel(rq.label);
                REQ_FETCH: expected_pairs.push_back(next_pair());
                REQ_CLEAR: restart_scan();
                default: ;
            endcase
            accept_count <= accept_count + 1;
        end
    end

    // Receiver back-pressure, with one long hold counted here
    always @(negedge aclk) begin
        int gap;
        gap = rx_gap;
        if (recv_count != recv_seen) begin
            recv_seen <= recv_count;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (long_hold && hold_cycles < HOLD_CYCLES) begin
            hold_cycles <= hold_cycles + 1;
            m_tready <= 1'b0;
        end else if (gap > 0) begin
            rx_gap <= gap - 1;
            m_tready <= 1'b0;
        end else begin
            rx_gap <= 0;
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        pair_reply_t exp_r;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            recv_count <= recv_count + 1;
            if (expected_pairs.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_r = expected_pairs.pop_front();
                fetch_count++;
                if (exp_r.found) found_count++;
                if (m_tdata[7:0] !== exp_r.src) begin
                    $error("source_label expected %0d got %0d", exp_r.src, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== exp_r.tgt) begin
                    $error("target_label expected %0d got %0d", exp_r.tgt, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[16] !== exp_r.err) begin
                    $error("range_error expected %0d got %0d", exp_r.err, m_tdata[16]);
                    fail_count++;
                end
                if (m_tuser !== exp_r.found) begin
                    $error("pair_found expected %0d got %0d", exp_r.found, m_tuser);
                    fail_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("label_map_adjacency_pairs_top verification failed");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEIGHT: cfg_height = val & 32'h7FF;
            REG_WIDTH:  cfg_width = val & 32'h1FFF;
            REG_COUNT:  cfg_count = val & 32'h1FF;
            default: ;
        endcase
    endtask

    // Wait until the block has drained every queued and expected transaction
    task automatic drain();
        while (pending_requests.size() > 0 || expected_pairs.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic void queue_req(req_t k, logic [15:0] lbl);
        request_t rq;
        rq.kind = k;
        rq.label = lbl;
        pending_requests.push_back(rq);
    endfunction

    function automatic logic [15:0] pick_label(int unsigned n);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'd0;
        if (sel == 1) return 16'($urandom_range(n + 1, 65535));
        if (sel == 2) return 16'hFFFF;
        return 16'($urandom_range(1, (n < 1) ? 1 : ((n > 6) ? 6 : n)) +
                   ((sel == 3) ? $urandom_range(0, n > 6 ? n - 6 : 0) : 0));
    endfunction

    // Random frames of labels and fetches, sometimes clear, then twelve more fetches
    task automatic random_phase(int unsigned h, int unsigned w, int unsigned n, int items);
        int issued;
        reg_write(REG_HEIGHT, h);
        reg_write(REG_WIDTH, w);
        reg_write(REG_COUNT, n);
        queue_req(REQ_CLEAR, 16'($urandom));
        issued = 0;
        while (issued < items) begin
            case ($urandom_range(0, 19))
                0: queue_req(REQ_FETCH, 16'($urandom));
                1: if ($urandom_range(0, 3) == 0) queue_req(REQ_NONE, 16'($urandom));
                2: if ($urandom_range(0, 7) == 0) queue_req(REQ_CLEAR, 16'($urandom));
                default: queue_req(REQ_PIXEL, pick_label(n));
            endcase
            issued++;
        end
        for (int i = 0; i < 12; i++) queue_req(REQ_FETCH, 16'($urandom));
        drain();
    endtask

    initial begin
        restart_scan();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: tiny 3x3 frame with known adjacencies and extreme labels
        reg_write(REG_HEIGHT, 3);
        reg_write(REG_WIDTH, 3);
        reg_write(REG_COUNT, 4);
        queue_req(REQ_FETCH, 16'h0);
        queue_req(REQ_PIXEL, 16'd1);
        queue_req(REQ_PIXEL, 16'd2);
        queue_req(REQ_PIXEL, 16'd1);
        queue_req(REQ_PIXEL, 16'd3);
        queue_req(REQ_PIXEL, 16'd0);
        queue_req(REQ_PIXEL, 16'd4);
        queue_req(REQ_PIXEL, 16'hFFFF);
        queue_req(REQ_PIXEL, 16'd2);
        queue_req(REQ_PIXEL, 16'd5);
        queue_req(REQ_NONE, 16'hFFFF);
        for (int i = 0; i < 8; i++) queue_req(REQ_FETCH, 16'hFFFF);
        queue_req(REQ_CLEAR, 16'h0);
        queue_req(REQ_FETCH, 16'h0);
        drain();

        // Largest label count: pair of top labels, and label count zero
        reg_write(REG_COUNT, 256);
        reg_write(REG_HEIGHT, 2);
        queue_req(REQ_PIXEL, 16'd256);
        queue_req(REQ_PIXEL, 16'd255);
        queue_req(REQ_PIXEL, 16'd257);
        queue_req(REQ_FETCH, 16'h0);
        queue_req(REQ_FETCH, 16'h0);
        drain();
        reg_write(REG_COUNT, 0);
        queue_req(REQ_PIXEL, 16'd1);
        queue_req(REQ_FETCH, 16'h0);
        drain();

        // Register extremes, including out-of-range sizes
        reg_write(REG_HEIGHT, 0);
        reg_write(REG_WIDTH, 0);
        reg_write(REG_COUNT, 511);
        queue_req(REQ_PIXEL, 16'd3);
        queue_req(REQ_PIXEL, 16'd9);
        queue_req(REQ_FETCH, 16'h0);
        drain();
        reg_write(REG_HEIGHT, 2047);
        reg_write(REG_WIDTH, 8191);
        queue_req(REQ_CLEAR, 16'h0);
        for (int i = 0; i < 40; i++) queue_req(REQ_PIXEL, 16'($urandom_range(1, 3)));
        queue_req(REQ_FETCH, 16'h0);
        drain();

        // Back-pressure: receiver holds off while fetches pile up
        long_hold = 1'b1;
        reg_write(REG_HEIGHT, 4);
        reg_write(REG_WIDTH, 4);
        reg_write(REG_COUNT, 8);
        queue_req(REQ_CLEAR, 16'h0);
        for (int i = 0; i < 16; i++) queue_req(REQ_PIXEL, 16'($urandom_range(1, 8)));
        for (int i = 0; i < 10; i++) queue_req(REQ_FETCH, 16'h0);
        wait (hold_cycles >= HOLD_CYCLES);
        long_hold = 1'b0;
        drain();

        // Random phases over several geometries, small frames mostly
        random_phase(1, 1, 1, 120);
        random_phase(3, 4, 5, 300);
        random_phase(5, 3, 12, 300);
        random_phase(2, 7, 3, 250);
        random_phase(1024, 2, 256, 200);
        random_phase(4, 4, 256, 300);
        random_phase(6, 5, 40, 300);

        $display("covered %0d fetch results, %0d returning a pair, across several frame sizes",
                 fetch_count, found_count);
        $display("label counts from zero to the maximum, with back-pressure on both sides");
        if (fail_count == 0) begin
            $display("label_map_adjacency_pairs_top verification clean");
        end else begin
            $display("label_map_adjacency_pairs_top verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/lmap_adj_pkg.sv
sv/lmap_adj_ram.sv
sv/label_map_adjacency_pairs_top.sv
tb/tb_label_map_adjacency_pairs_top.sv
